// File: hw/rtl/stkn_pkg.sv
// Shared types, token codes and helper functions for the source text tokenizer.
`default_nettype none

package stkn_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_marker;
    } in_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic [5:0]  token_length;
        logic [63:0] integer_value;
        logic        last_of_item;
    } out_t;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_ZERO  = 4'd1,
        MODE_HEXP  = 4'd2,
        MODE_BINP  = 4'd3,
        MODE_DEC   = 4'd4,
        MODE_HEX   = 4'd5,
        MODE_BIN   = 4'd6,
        MODE_IDENT = 4'd7,
        MODE_LT    = 4'd8,
        MODE_GT    = 4'd9,
        MODE_UNDEF = 4'd10
    } mode_t;

    localparam logic [4:0] KIND_IDENT  = 5'd0;
    localparam logic [4:0] KIND_INT    = 5'd1;
    localparam logic [4:0] KIND_PLUS   = 5'd2;
    localparam logic [4:0] KIND_MINUS  = 5'd3;
    localparam logic [4:0] KIND_STAR   = 5'd4;
    localparam logic [4:0] KIND_SLASH  = 5'd5;
    localparam logic [4:0] KIND_EQ     = 5'd6;
    localparam logic [4:0] KIND_SEMI   = 5'd7;
    localparam logic [4:0] KIND_LBRACE = 5'd8;
    localparam logic [4:0] KIND_RBRACE = 5'd9;
    localparam logic [4:0] KIND_LPAREN = 5'd10;
    localparam logic [4:0] KIND_RPAREN = 5'd11;
    localparam logic [4:0] KIND_AMP    = 5'd12;
    localparam logic [4:0] KIND_CARET  = 5'd13;
    localparam logic [4:0] KIND_BAR    = 5'd14;
    localparam logic [4:0] KIND_TILDE  = 5'd15;
    localparam logic [4:0] KIND_LSHIFT = 5'd16;
    localparam logic [4:0] KIND_RSHIFT = 5'd17;
    localparam logic [4:0] KIND_KW0    = 5'd18;
    localparam logic [4:0] KIND_UNDEF  = 5'd30;
    localparam logic [4:0] KIND_EOF    = 5'd31;

    localparam int KW_COUNT = 12;

    localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
        40'h6938, 40'h693136, 40'h693332, 40'h693634,
        40'h7538, 40'h753136, 40'h753332, 40'h753634,
        40'h626F6F6C, 40'h74727565, 40'h66616C7365, 40'h6173
    };

    localparam logic [5:0] KW_LEN [KW_COUNT] = '{
        6'd2, 6'd3, 6'd3, 6'd3, 6'd2, 6'd3, 6'd3, 6'd3, 6'd4, 6'd4, 6'd5, 6'd2
    };

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v != 16'hFFFF) ? v + 16'd1 : v;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == 8'h5F);
    endfunction

    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        k = KIND_IDENT;
        unique case (c)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h3D:   k = KIND_EQ;
            8'h3B:   k = KIND_SEMI;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h26:   k = KIND_AMP;
            8'h5E:   k = KIND_CARET;
            8'h7C:   k = KIND_BAR;
            8'h7E:   k = KIND_TILDE;
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

    // digit count of v: one plus the number of powers of ten from ten up not above v, at most cap
    function automatic logic [5:0] dec_digits(input logic [63:0] v, input logic [5:0] cap);
        logic [63:0] pow;
        logic [5:0]  n;
        pow = 64'd1;
        n   = 6'd1;
        for (int k = 1; k < 20; k++) begin
            pow = pow * 64'd10;
            if (v >= pow) n = n + 6'd1;
        end
        return (n > cap) ? cap : n;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stkn_front.sv
// Front end: scans bytes, keeps line and column counters, forms up to two tokens per byte.
`default_nettype none

module stkn_front
    import stkn_pkg::*;
#(
    parameter int LEN_CAP = 63
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire in_t        item,
    output logic [1:0]      push_cnt,
    output out_t            push0,
    output out_t            push1
);

    localparam logic [5:0] CAP = 6'(LEN_CAP);

    mode_t       mode_reg,  mode_next;
    logic [15:0] line_reg,  line_next;
    logic [15:0] col_reg,   col_next;
    logic [15:0] start_reg, start_next;
    logic [5:0]  len_reg,   len_next;
    logic [63:0] acc_reg,   acc_next;
    logic [39:0] win_reg,   win_next;

    logic [7:0]  c;
    logic [15:0] take_col;
    logic [5:0]  take_len;
    logic [39:0] take_win;
    logic        flush_v, emit_v, do_idle, consumed, dig_ok;
    logic [3:0]  dig;
    logic [63:0] acc_step;
    out_t        flush_tok, emit_tok;
    logic [4:0]  id_kind;

    assign c        = item.text_byte;
    assign take_col = sat_inc(col_reg);
    assign take_len = (len_reg < CAP) ? len_reg + 6'd1 : len_reg;
    assign take_win = {win_reg[31:0], c};

    always_comb
    begin
        id_kind = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len_reg == KW_LEN[i] && win_reg == KW_TEXT[i]) id_kind = KIND_KW0 + 5'(i);
        end
    end

    always_comb
    begin
        flush_tok               = '0;
        flush_tok.token_line    = line_reg;
        flush_tok.token_column  = start_reg;
        flush_tok.token_length  = len_reg;
        unique case (mode_reg)
            MODE_ZERO, MODE_DEC, MODE_HEX, MODE_BIN:
            begin
                flush_tok.token_kind    = KIND_INT;
                flush_tok.integer_value = acc_reg;
            end
            MODE_IDENT: flush_tok.token_kind = id_kind;
            default:    flush_tok.token_kind = KIND_UNDEF;
        endcase
    end

    always_comb
    begin
        dig    = 4'd0;
        dig_ok = 1'b0;
        acc_step = acc_reg;
        unique case (mode_reg)
            MODE_HEXP, MODE_HEX:
            begin
                if (is_digit(c))
                begin
                    dig = 4'(c - 8'h30); dig_ok = 1'b1;
                end
                else if (c >= 8'h61 && c <= 8'h66)
                begin
                    dig = 4'(c - 8'h57); dig_ok = 1'b1;
                end
                else if (c >= 8'h41 && c <= 8'h46)
                begin
                    dig = 4'(c - 8'h37); dig_ok = 1'b1;
                end
                acc_step = {acc_reg[59:0], dig};
            end
            MODE_BINP, MODE_BIN:
            begin
                dig_ok   = (c == 8'h30) || (c == 8'h31);
                dig      = {3'd0, c[0]};
                acc_step = {acc_reg[62:0], c[0]};
            end
            default:
            begin
                dig_ok   = is_digit(c);
                dig      = 4'(c - 8'h30);
                acc_step = {acc_reg[60:0], 3'd0} + {acc_reg[62:0], 1'b0} + {60'd0, dig};
            end
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        win_next   = win_reg;
        flush_v    = 1'b0;
        emit_v     = 1'b0;
        emit_tok   = '0;
        emit_tok.token_line = line_reg;
        do_idle    = 1'b0;
        consumed   = 1'b1;

        if (item.end_marker)
        begin
            flush_v                = (mode_reg != MODE_IDLE);
            emit_v                 = 1'b1;
            emit_tok.token_kind    = KIND_EOF;
            emit_tok.token_column  = col_reg;
            mode_next  = MODE_IDLE;
            line_next  = 16'd1;
            col_next   = 16'd1;
            start_next = 16'd1;
            len_next   = 6'd0;
            acc_next   = 64'd0;
            win_next   = 40'd0;
        end
        else
        begin
            priority case (mode_reg)
                MODE_IDLE: do_idle = 1'b1;
                MODE_ZERO, MODE_DEC, MODE_HEXP, MODE_HEX, MODE_BINP, MODE_BIN:
                begin
                    if (mode_reg == MODE_ZERO && (c == 8'h78 || c == 8'h58))
                        mode_next = MODE_HEXP;
                    else if (mode_reg == MODE_ZERO && (c == 8'h62 || c == 8'h42))
                        mode_next = MODE_BINP;
                    else if (dig_ok)
                    begin
                        acc_next = acc_step;
                        if (mode_reg == MODE_ZERO) mode_next = MODE_DEC;
                        else if (mode_reg == MODE_HEXP) mode_next = MODE_HEX;
                        else if (mode_reg == MODE_BINP) mode_next = MODE_BIN;
                    end
                    else if (mode_reg == MODE_HEXP || mode_reg == MODE_BINP)
                    begin
                        if (is_ws(c)) consumed = 1'b0;
                        else mode_next = MODE_UNDEF;
                    end
                    else if (is_word(c)) mode_next = MODE_UNDEF;
                    else consumed = 1'b0;
                end
                MODE_IDENT: consumed = is_word(c);
                MODE_LT, MODE_GT:
                begin
                    if ((mode_reg == MODE_LT && c == 8'h3C) || (mode_reg == MODE_GT && c == 8'h3E))
                    begin
                        emit_v                = 1'b1;
                        emit_tok.token_kind   = (mode_reg == MODE_LT) ? KIND_LSHIFT : KIND_RSHIFT;
                        emit_tok.token_column = start_reg;
                        emit_tok.token_length = 6'd2;
                        mode_next             = MODE_IDLE;
                    end
                    else if (is_ws(c)) consumed = 1'b0;
                    else mode_next = MODE_UNDEF;
                end
                default: consumed = !is_ws(c);
            endcase

            if (mode_reg != MODE_IDLE)
            begin
                if (consumed)
                begin
                    col_next = take_col;
                    len_next = take_len;
                    win_next = take_win;
                end
                else
                begin
                    flush_v   = 1'b1;
                    do_idle   = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end

            if (do_idle)
            begin
                if (c == 8'd10)
                begin
                    line_next = sat_inc(line_reg);
                    col_next  = 16'd1;
                end
                else if (is_ws(c))
                    col_next = take_col;
                else
                begin
                    start_next = col_reg;
                    col_next   = take_col;
                    len_next   = (CAP != 6'd0) ? 6'd1 : 6'd0;
                    win_next   = {32'd0, c};
                    acc_next   = 64'd0;
                    if (c == 8'h30) mode_next = MODE_ZERO;
                    else if (is_digit(c))
                    begin
                        mode_next = MODE_DEC;
                        acc_next  = {60'd0, 4'(c - 8'h30)};
                    end
                    else if (is_alpha(c) || c == 8'h5F) mode_next = MODE_IDENT;
                    else if (c == 8'h3C) mode_next = MODE_LT;
                    else if (c == 8'h3E) mode_next = MODE_GT;
                    else if (op_kind(c) != KIND_IDENT)
                    begin
                        emit_v                = 1'b1;
                        emit_tok.token_kind   = op_kind(c);
                        emit_tok.token_column = col_reg;
                        emit_tok.token_length = 6'd1;
                        mode_next             = MODE_IDLE;
                    end
                    else mode_next = MODE_UNDEF;
                end
            end
        end
    end

    always_comb
    begin
        push_cnt = {1'b0, flush_v} + {1'b0, emit_v};
        push0    = flush_v ? flush_tok : emit_tok;
        push1    = emit_tok;
        push0.last_of_item = !(flush_v && emit_v);
        push1.last_of_item = 1'b1;
        if (!accept) push_cnt = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= 16'd1;
            col_reg   <= 16'd1;
            start_reg <= 16'd1;
            len_reg   <= 6'd0;
            acc_reg   <= 64'd0;
            win_reg   <= 40'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            win_reg   <= win_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/stkn_queue.sv
// Short token queue between front and back: up to two pushes and one pop per cycle.
`default_nettype none

module stkn_queue
    import stkn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] push_cnt,
    input  wire out_t       push0,
    input  wire out_t       push1,
    input  wire logic       pop,
    output out_t            head,
    output logic            not_empty,
    output logic            room
);

    localparam int DEPTH = 4;

    out_t       mem [DEPTH];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;

    assign head      = mem[rd_reg];
    assign not_empty = (cnt_reg != 3'd0);
    assign room      = (cnt_reg <= 3'(DEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg + push_cnt;
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, push_cnt} - {2'd0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0) mem[wr_reg] <= push0;
        if (push_cnt == 2'd2) mem[wr_reg + 2'd1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(DEPTH))
        else $error("token queue count beyond depth");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 3'd0)
        else $error("token queue popped while empty");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> cnt_reg <= 3'(DEPTH - 2))
        else $error("token queue pushed without room");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        2'(wr_reg - rd_reg) == cnt_reg[1:0])
        else $error("token queue pointers disagree with count");

endmodule

`default_nettype wire

// File: hw/rtl/stkn_back.sv
// Back end: finishes integer lengths and holds the result register toward the sink.
`default_nettype none

module stkn_back
    import stkn_pkg::*;
#(
    parameter int LEN_CAP = 63
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire out_t head,
    input  wire logic not_empty,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_item
);

    logic valid_reg, valid_next;
    out_t item_reg,  item_next;

    assign pop       = not_empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next = head;
        if (head.token_kind == KIND_INT)
            item_next.token_length = dec_digits(head.integer_value, 6'(LEN_CAP));
        valid_next = pop || (valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop) item_reg <= item_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/source_text_tokenizer.sv
// Top level of the source text tokenizer: front scanner, token queue and result stage.
//
// Takes one source byte (or an end marker) per cycle and produces tokens with kind, line,
// column, length and integer value; a byte yields at most two tokens, the last one flagged.
// A byte is taken every cycle while the four-entry token queue has room for two more
// tokens; with the sink taking one token a cycle, only bytes that complete two tokens at
// once (such as an operator right after a word, or the end marker after an unfinished
// token) can fill the queue and pause input. Each token is queued, then registered.
`default_nettype none

module source_text_tokenizer
    import stkn_pkg::*;
#(
    parameter int MAX_TEXT_SIZE = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_item
);

    localparam int LEN_CAP = ((MAX_TEXT_SIZE - 1) < 63) ? (MAX_TEXT_SIZE - 1) : 63;

    logic       accept, pop, not_empty, room;
    logic [1:0] push_cnt;
    out_t       push0, push1, head;

    assign in_ready = room;
    assign accept   = in_valid && room;

    stkn_front #(.LEN_CAP(LEN_CAP)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (in_item),
        .push_cnt (push_cnt),
        .push0    (push0),
        .push1    (push1)
    );

    stkn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (push0),
        .push1     (push1),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .room      (room)
    );

    stkn_back #(.LEN_CAP(LEN_CAP)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
